### src/cgu_pkg.sv
// Shared constants, codes and the item record of the contour grid upsampler.
`default_nettype none

package cgu_pkg;

    // Fixed field widths of the channels and the configuration port
    localparam int VALUE_W   = 16;
    localparam int COORD_W   = 11;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    // Default build limits
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_PIXEL_BITS = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // Everything the cell sequencer needs to expand one pixel
    typedef struct packed {
        logic [COORD_W-1:0] row_base;   // doubled row just above the pixel
        logic [COORD_W-1:0] col_base;   // doubled column just left of the pixel
        logic [VALUE_W-1:0] pix;
        logic [VALUE_W-1:0] hedge;
        logic [VALUE_W-1:0] vedge;
        logic               first_row;
        logic               first_col;
        logic               last_row;
        logic               last_col;
    } cgu_item_t;

endpackage

`default_nettype wire

### src/cgu_if.sv
// Valid/ready stream interfaces for pixel items and cell items.
`default_nettype none

interface cgu_pix_if
    import cgu_pkg::*;
    ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

interface cgu_cell_if
    import cgu_pkg::*;
    ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic [VALUE_W-1:0] cell_value;
    logic               run_last;
    logic               frame_last;

    modport source (output valid, output out_row, output out_col, output cell_value,
                    output run_last, output frame_last, input ready);
    modport sink   (input valid, input out_row, input out_col, input cell_value,
                    input run_last, input frame_last, output ready);
endinterface

`default_nettype wire

### src/cgu_expand.sv
// Cell sequencer: turns a pixel item into doubled-grid cells, one per cycle unless stalled.
`default_nettype none

module cgu_expand
    import cgu_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    output logic           item_ready,
    input  wire cgu_item_t item,
    cgu_cell_if.source     grid
);

    cgu_item_t   item_reg;
    logic        busy_reg;
    logic [1:0]  ph_reg;
    logic [1:0]  ph_next;
    logic [1:0]  k_reg;
    logic [1:0]  k_next;
    logic        busy_next;

    logic        out_valid_reg;
    logic [COORD_W-1:0] out_row_reg;
    logic [COORD_W-1:0] out_col_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic        out_run_last_reg;
    logic        out_frame_last_reg;

    logic        emit;
    logic        take;
    logic        last_cell;
    logic [1:0]  ph_end;
    logic [1:0]  k_start;
    logic [1:0]  k_end;
    logic [VALUE_W-1:0] cell_val;

    // Bounds of the current cell walk
    assign ph_end    = item_reg.last_row ? 2'd2 : 2'd1;
    assign k_start   = item_reg.first_col ? 2'd1 : 2'd0;
    assign k_end     = item_reg.last_col ? 2'd2 : 2'd1;
    assign last_cell = (ph_reg == ph_end) && (k_reg == k_end);

    // Advance when the output register is free or being drained
    assign emit       = busy_reg && (!out_valid_reg || grid.ready);
    assign item_ready = !busy_reg || (emit && last_cell);
    assign take       = item_valid && item_ready;

    // Cell value: top row 0 at k=0 else vertical edge, lower rows hedge at k=0 else pixel
    always_comb
    begin
        if (ph_reg == 2'd0)
            cell_val = (k_reg == 2'd0) ? '0 : item_reg.vedge;
        else
            cell_val = (k_reg == 2'd0) ? item_reg.hedge : item_reg.pix;
    end

    // Next walk position
    always_comb
    begin
        ph_next   = ph_reg;
        k_next    = k_reg;
        busy_next = busy_reg;
        if (take)
        begin
            busy_next = 1'b1;
            ph_next   = item.first_row ? 2'd1 : 2'd0;
            k_next    = item.first_col ? 2'd1 : 2'd0;
        end
        else if (emit)
        begin
            if (last_cell)
                busy_next = 1'b0;
            else if (k_reg == k_end)
            begin
                k_next  = k_start;
                ph_next = ph_reg + 2'd1;
            end
            else
                k_next = k_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ph_reg   <= 2'd0;
            k_reg    <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            ph_reg   <= ph_next;
            k_reg    <= k_next;
        end
    end

    // Hold the item being expanded
    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= item;
    end

    // Output register: load on emit, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (grid.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_row_reg        <= item_reg.row_base + COORD_W'(ph_reg);
            out_col_reg        <= item_reg.col_base + COORD_W'(k_reg);
            out_value_reg      <= cell_val;
            out_run_last_reg   <= last_cell;
            out_frame_last_reg <= last_cell && item_reg.last_row && item_reg.last_col;
        end
    end

    assign grid.valid      = out_valid_reg;
    assign grid.out_row    = out_row_reg;
    assign grid.out_col    = out_col_reg;
    assign grid.cell_value = out_value_reg;
    assign grid.run_last   = out_run_last_reg;
    assign grid.frame_last = out_frame_last_reg;

`ifndef NO_ASSERTIONS
    // Walk position never leaves the window of the item
    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (ph_reg <= ph_end) && (k_reg <= k_end))
        else $error("cell walk out of range");

    // A stalled walk keeps its position
    a_walk_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !emit) |=> $stable(ph_reg) && $stable(k_reg))
        else $error("cell walk moved while stalled");

    // The frame's final cell closes its pixel's run
    a_frame_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_frame_last_reg) |-> out_run_last_reg)
        else $error("frame end without run end");
`endif

endmodule

`default_nettype wire

### src/contour_grid_upsampler_core.sv
// Top level of the contour grid upsampler: counters, line store and cell sequencer.
`default_nettype none

// Pixels enter in raster order and leave as doubled-grid cells, one cell per cycle on the
// output while the receiver keeps taking them. A pixel yields from 1 cell, for the first
// pixel of a frame, up to 9 for the last pixel of the last row, about 4 on average over a
// frame. The next pixel is accepted while the previous one is still being expanded, so
// while pixels keep coming the cells of one follow those of the one before without a gap.
// The first cell of a pixel passes the line-store read and pixel hold registers, then the
// sequencer's item register, then the output register. The line store holding the
// previous row is not cleared after reset: reset and any register write restart the
// frame, and the first row of a frame makes no cells from what it reads there. A write
// to image_width or image_height restarts the frame; values of zero count as one and
// values above the build limit count as the limit. Write the registers only while no
// pixel is in flight.
module contour_grid_upsampler_core
    import cgu_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    cgu_pix_if.sink                   pixel,
    cgu_cell_if.source                grid
);

    localparam int CB    = $clog2(MAX_WIDTH);
    localparam int RB    = $clog2(MAX_HEIGHT);
    localparam int PIX_W = (PIXEL_BITS < VALUE_W) ? PIXEL_BITS : VALUE_W;
    localparam logic [CB-1:0] WIDTH_LAST_RST  =
        CB'(((MAX_WIDTH < 1024) ? MAX_WIDTH : 1024) - 1);
    localparam logic [RB-1:0] HEIGHT_LAST_RST =
        RB'(((MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024) - 1);

    logic [CB-1:0]    width_last_reg;
    logic [CB-1:0]    width_last_next;
    logic [RB-1:0]    height_last_reg;
    logic [RB-1:0]    height_last_next;
    logic [CB-1:0]    col_reg;
    logic [CB-1:0]    col_next;
    logic [RB-1:0]    row_reg;
    logic [RB-1:0]    row_next;
    logic [PIX_W-1:0] left_reg;
    logic [PIX_W-1:0] left_next;

    logic [PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [PIX_W-1:0] above_reg;

    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic [PIX_W-1:0] s1_pix_reg;
    logic [PIX_W-1:0] s1_left_reg;
    logic [CB-1:0]    s1_col_reg;
    logic [RB-1:0]    s1_row_reg;
    logic             s1_last_col_reg;
    logic             s1_last_row_reg;

    logic             accept;
    logic             item_ready;
    logic [PIX_W-1:0] pix_in;
    logic [PIX_W-1:0] hedge;
    logic [PIX_W-1:0] vedge;
    cgu_item_t        item;

    assign pix_in       = pixel.pixel_value[PIX_W-1:0];
    assign pixel.ready  = !s1_valid_reg || item_ready;
    assign accept       = pixel.valid && pixel.ready;

    // Clamp a written dimension and keep it as its last index
    always_comb
    begin
        width_last_next  = width_last_reg;
        height_last_next = height_last_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:
                begin
                    if (cfg_data == '0)
                        width_last_next = '0;
                    else if (int'(cfg_data) > MAX_WIDTH)
                        width_last_next = CB'(MAX_WIDTH - 1);
                    else
                        width_last_next = CB'(int'(cfg_data) - 1);
                end
                REG_IMAGE_HEIGHT:
                begin
                    if (cfg_data == '0)
                        height_last_next = '0;
                    else if (int'(cfg_data) > MAX_HEIGHT)
                        height_last_next = RB'(MAX_HEIGHT - 1);
                    else
                        height_last_next = RB'(int'(cfg_data) - 1);
                end
                default:
                begin
                    width_last_next  = width_last_reg;
                    height_last_next = height_last_reg;
                end
            endcase
        end
    end

    // Advance the raster position; a register write restarts the frame
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        left_next = left_reg;
        if (cfg_we)
        begin
            col_next  = '0;
            row_next  = '0;
            left_next = '0;
        end
        else if (accept)
        begin
            left_next = pix_in;
            if (col_reg == width_last_reg)
            begin
                col_next = '0;
                row_next = (row_reg == height_last_reg) ? '0 : row_reg + RB'(1);
            end
            else
                col_next = col_reg + CB'(1);
        end
    end

    assign s1_valid_next = accept ? 1'b1 : (item_ready ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_last_reg  <= WIDTH_LAST_RST;
            height_last_reg <= HEIGHT_LAST_RST;
            col_reg         <= '0;
            row_reg         <= '0;
            left_reg        <= '0;
            s1_valid_reg    <= 1'b0;
        end
        else
        begin
            width_last_reg  <= width_last_next;
            height_last_reg <= height_last_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            left_reg        <= left_next;
            s1_valid_reg    <= s1_valid_next;
        end
    end

    // Line store: read the pixel above and replace it with the new one
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_mem[col_reg] <= pix_in;
            above_reg         <= line_mem[col_reg];
        end
    end

    // Hold the accepted pixel while its upper neighbor is read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg      <= pix_in;
            s1_left_reg     <= left_reg;
            s1_col_reg      <= col_reg;
            s1_row_reg      <= row_reg;
            s1_last_col_reg <= (col_reg == width_last_reg);
            s1_last_row_reg <= (row_reg == height_last_reg);
        end
    end

    // Edge minima
    assign hedge = (s1_left_reg < s1_pix_reg) ? s1_left_reg : s1_pix_reg;
    assign vedge = (above_reg < s1_pix_reg) ? above_reg : s1_pix_reg;

    // Build the item for the sequencer
    always_comb
    begin
        item.row_base  = COORD_W'({s1_row_reg, 1'b0}) - COORD_W'(1);
        item.col_base  = COORD_W'({s1_col_reg, 1'b0}) - COORD_W'(1);
        item.pix       = VALUE_W'(s1_pix_reg);
        item.hedge     = VALUE_W'(hedge);
        item.vedge     = VALUE_W'(vedge);
        item.first_row = (s1_row_reg == '0);
        item.first_col = (s1_col_reg == '0);
        item.last_row  = s1_last_row_reg;
        item.last_col  = s1_last_col_reg;
    end

    cgu_expand u_expand (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (s1_valid_reg),
        .item_ready (item_ready),
        .item       (item),
        .grid       (grid)
    );

`ifndef NO_ASSERTIONS
    // Read data of the line store stays put while its pixel waits for the sequencer
    a_above_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !item_ready) |=> $stable(above_reg) && s1_valid_reg)
        else $error("line store data lost while waiting");

    // Raster position stays inside the frame
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg <= width_last_reg) && (row_reg <= height_last_reg))
        else $error("raster position outside frame");

    // A register write restarts the frame
    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (col_reg == '0) && (row_reg == '0) && (left_reg == '0))
        else $error("frame not restarted after register write");
`endif

endmodule

`default_nettype wire

### sim/contour_grid_upsampler_core_test.sv
// Self-checking testbench of the contour grid upsampler: random pixel frames against a cell predictor.
module contour_grid_upsampler_core_test;
    import cgu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W = DEF_MAX_WIDTH;
    localparam int MAX_H = DEF_MAX_HEIGHT;
    localparam int RANDOM_ITEMS = 260;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [VALUE_W-1:0] value;
        logic               run_last;
        logic               frame_last;
    } cell_rec_t;

    typedef struct {
        logic [VALUE_W-1:0] value;
        bit                 drain;
    } pixel_req_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    cgu_pix_if  pix_ch ();
    cgu_cell_if cell_ch ();

    contour_grid_upsampler_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pix_ch),
        .grid      (cell_ch)
    );

    always #5 clk = ~clk;

    // Predictor state: registers, counters, previous row and left neighbour
    logic [CFG_W-1:0]   width_reg = CFG_W'(1024);
    logic [CFG_W-1:0]   height_reg = CFG_W'(1024);
    int unsigned        row_cnt = 0;
    int unsigned        col_cnt = 0;
    logic [VALUE_W-1:0] left_pix = '0;
    logic [VALUE_W-1:0] line_mem [MAX_W];

    cell_rec_t  cells_due [$];
    pixel_req_t pixels_pending [$];
    int unsigned pix_queued = 0;
    int unsigned pix_taken = 0;
    int unsigned fail_cnt = 0;

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned maxv);
        if (v < 1) return 1;
        if (v > maxv) return maxv;
        return int'(v);
    endfunction

    function automatic void push_cell(input int unsigned row, input int unsigned col,
                                      input logic [VALUE_W-1:0] v);
        cell_rec_t rec;
        rec.row = COORD_W'(row);
        rec.col = COORD_W'(col);
        rec.value = v;
        rec.run_last = 1'b0;
        rec.frame_last = 1'b0;
        cells_due.push_back(rec);
    endfunction

    // Doubled pixel row or last-row repeat: horizontal edge, the pixel, and the last-column repeat
    function automatic void push_even_row(input int unsigned row, input int unsigned c,
                                          input logic [VALUE_W-1:0] hedge,
                                          input logic [VALUE_W-1:0] pix, input bit lc);
        if (c > 0) push_cell(row, 2 * c - 1, hedge);
        push_cell(row, 2 * c, pix);
        if (lc) push_cell(row, 2 * c + 1, pix);
    endfunction

    // Expand one accepted pixel into the doubled-grid cells it completes
    function automatic void expand_pixel(input logic [VALUE_W-1:0] pix);
        int unsigned        w;
        int unsigned        h;
        int unsigned        c;
        int unsigned        r;
        logic [VALUE_W-1:0] above;
        logic [VALUE_W-1:0] hedge;
        logic [VALUE_W-1:0] vedge;
        bit                 lc;
        bit                 lr;
        cell_rec_t          tail;
        w = clamp_dim(width_reg, MAX_W);
        h = clamp_dim(height_reg, MAX_H);
        c = col_cnt;
        r = row_cnt;
        if (c >= w) c = 0;
        if (r >= h) r = 0;
        above = line_mem[c];
        hedge = (left_pix < pix) ? left_pix : pix;
        vedge = (above < pix) ? above : pix;
        lc = (c == w - 1);
        lr = (r == h - 1);
        if (r > 0)
        begin
            if (c > 0) push_cell(2 * r - 1, 2 * c - 1, '0);
            push_cell(2 * r - 1, 2 * c, vedge);
            if (lc) push_cell(2 * r - 1, 2 * c + 1, vedge);
        end
        push_even_row(2 * r, c, hedge, pix, lc);
        if (lr) push_even_row(2 * r + 1, c, hedge, pix, lc);
        // Mark the last cell of this pixel, and of the frame
        tail = cells_due.pop_back();
        tail.run_last = 1'b1;
        tail.frame_last = lr && lc;
        cells_due.push_back(tail);
        // Advance the raster position
        line_mem[c] = pix;
        left_pix = pix;
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_cnt = c;
        row_cnt = r;
    endfunction

    function automatic int unsigned draw_gap(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 9);
    endfunction

    function automatic logic [VALUE_W-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return VALUE_W'($urandom_range(0, 15));
            3: return VALUE_W'(16'hFFFF - $urandom_range(0, 15));
            default: return VALUE_W'($urandom());
        endcase
    endfunction

    // Pick a frame dimension: mostly small, sometimes zero or larger
    function automatic int unsigned pick_dim();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return $urandom_range(7, 24);
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    // Pixel driver
    int unsigned gap_left = 0;
    bit          drv_quiet = 1'b0;
    bit          pix_take;
    pixel_req_t  pix_next;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_ch.valid <= 1'b0;
            pix_ch.pixel_value <= '0;
            gap_left = 0;
        end
        else
        begin
            pix_take = pix_ch.valid && pix_ch.ready;
            if (pix_take)
            begin
                expand_pixel(pix_ch.pixel_value);
                pix_taken++;
                gap_left = draw_gap(drv_quiet);
                if ($urandom_range(0, 24) == 0) drv_quiet = !drv_quiet;
            end
            if (pix_ch.valid && !pix_take)
            begin
                // hold the offered item
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                pix_ch.valid <= 1'b0;
            end
            else if (pixels_pending.size() > 0 &&
                     (!pixels_pending[0].drain || cells_due.size() == 0))
            begin
                pix_next = pixels_pending.pop_front();
                pix_ch.valid <= 1'b1;
                pix_ch.pixel_value <= pix_next.value;
            end
            else
            begin
                pix_ch.valid <= 1'b0;
            end
        end
    end

    // Cell monitor: stall at random, compare every item with the oldest expectation
    int unsigned stall_left = 0;
    bit          mon_quiet = 1'b0;
    cell_rec_t   cell_got;
    cell_rec_t   cell_want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (cell_ch.valid && cell_ch.ready)
            begin
                cell_got.row = cell_ch.out_row;
                cell_got.col = cell_ch.out_col;
                cell_got.value = cell_ch.cell_value;
                cell_got.run_last = cell_ch.run_last;
                cell_got.frame_last = cell_ch.frame_last;
                if (cells_due.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("unexpected cell: row %0d col %0d value %h run_last %b frame_last %b",
                                 cell_got.row, cell_got.col, cell_got.value,
                                 cell_got.run_last, cell_got.frame_last);
                end
                else
                begin
                    cell_want = cells_due.pop_front();
                    if (cell_got !== cell_want)
                    begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display({"cell mismatch: got r%0d c%0d v%h rl%b fl%b, ",
                                      "want r%0d c%0d v%h rl%b fl%b"},
                                     cell_got.row, cell_got.col, cell_got.value,
                                     cell_got.run_last, cell_got.frame_last,
                                     cell_want.row, cell_want.col, cell_want.value,
                                     cell_want.run_last, cell_want.frame_last);
                    end
                end
                stall_left = draw_gap(mon_quiet);
                if ($urandom_range(0, 29) == 0) mon_quiet = !mon_quiet;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                cell_ch.ready <= 1'b0;
            end
            else
            begin
                cell_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_pixel(input logic [VALUE_W-1:0] v, input bit drain);
        pixel_req_t req;
        req.value = v;
        req.drain = drain;
        pixels_pending.push_back(req);
        pix_queued++;
    endtask

    // Wait until every item is accepted and every cell has arrived
    task automatic wait_idle();
        while (pix_taken != pix_queued || cells_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write one register; any write restarts the frame
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == REG_IMAGE_WIDTH)
            width_reg = val;
        else
            height_reg = val;
        row_cnt = 0;
        col_cnt = 0;
        left_pix = '0;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_dims(input int unsigned w, input int unsigned h);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
        write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
    endtask

    // Stimulus and end of run
    int unsigned rnd_cnt = 0;
    int unsigned phase_w;
    int unsigned phase_h;
    int unsigned phase_n;

    initial
    begin
        pix_ch.valid = 1'b0;
        pix_ch.pixel_value = '0;
        cell_ch.ready = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default frame size after reset, first row only
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'h8001, 1'b0);

        // Single-pixel frame: every pixel ends a frame, counters wrap
        set_dims(1, 1);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'h0000, 1'b0);

        // 2x2 frame with extreme values; hold off before the third pixel
        set_dims(2, 2);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'h0000, 1'b1);
        send_pixel(16'hFFFF, 1'b0);

        // Restart in the middle of a frame, then a full 3x2 frame
        set_dims(3, 2);
        send_pixel(16'h00FF, 1'b0);
        send_pixel(16'hFF00, 1'b0);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, CFG_W'(3));
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'h0001, 1'b0);
        send_pixel(16'h8000, 1'b0);
        send_pixel(16'h7FFF, 1'b0);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'h0000, 1'b0);

        // Zero counts as one, above the limit counts as the limit
        set_dims(0, 0);
        send_pixel(16'h5A5A, 1'b0);
        send_pixel(16'hA5A5, 1'b0);
        set_dims(2047, 2047);
        send_pixel(16'h1234, 1'b0);
        send_pixel(16'hEDCB, 1'b0);

        // Random frames, mostly whole, some cut short by a restart
        while (rnd_cnt < RANDOM_ITEMS)
        begin
            phase_w = pick_dim();
            phase_h = pick_dim();
            wait_idle();
            case ($urandom_range(0, 5))
                0: write_reg(REG_IMAGE_WIDTH, CFG_W'(phase_w));
                1: write_reg(REG_IMAGE_HEIGHT, CFG_W'(phase_h));
                2:
                begin
                    write_reg(REG_IMAGE_HEIGHT, CFG_W'(phase_h));
                    write_reg(REG_IMAGE_WIDTH, CFG_W'(phase_w));
                end
                default:
                begin
                    write_reg(REG_IMAGE_WIDTH, CFG_W'(phase_w));
                    write_reg(REG_IMAGE_HEIGHT, CFG_W'(phase_h));
                end
            endcase
            phase_n = clamp_dim(width_reg, MAX_W) * clamp_dim(height_reg, MAX_H)
                      * $urandom_range(1, 2);
            if ($urandom_range(0, 4) == 0) phase_n = $urandom_range(1, phase_n);
            if (phase_n > 150) phase_n = 150;
            if (phase_n > RANDOM_ITEMS - rnd_cnt) phase_n = RANDOM_ITEMS - rnd_cnt;
            repeat (phase_n)
            begin
                send_pixel(rand_pixel(), $urandom_range(0, 59) == 0);
                rnd_cnt++;
            end
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (fail_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #(10_000_000);
        $display("Test completed with failures");
        $finish;
    end

endmodule

### files.f
src/cgu_pkg.sv
src/cgu_if.sv
src/cgu_expand.sv
src/contour_grid_upsampler_core.sv
sim/contour_grid_upsampler_core_test.sv
